// ----- sv/acfp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared types, defaults and constant tables for the ASCII checksum frame
// parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

	localparam int unsigned MAX_LINE_DEF   = 500;
	localparam int unsigned MAX_FIELDS_DEF = 12;

	localparam int unsigned VALUE_W = 48;
	localparam int unsigned FRAC_W  = 54;

	// 5^16: one step of the 16-bit binary fraction on the 16-digit decimal fraction.
	localparam logic [37:0] FRAC_DIV   = 38'd152587890625;
	// Reciprocal of 5^16 scaled by 2^69, applied to the top 32 bits of the fraction.
	localparam logic [31:0] FRAC_RECIP = 32'd3868562622;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic wr_comma;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic eol;
		logic comma_kept;
		logic emit_any;
		logic div_last;
		logic k_last;
	} status_t;

	// Weight of a fraction digit, 10^idx, on a 16-digit decimal fraction.
	function automatic logic [FRAC_W-1:0] frac_weight(input logic [3:0] idx);
		logic [FRAC_W-1:0] w;
		case (idx)
			4'd0:    w = 54'd1;
			4'd1:    w = 54'd10;
			4'd2:    w = 54'd100;
			4'd3:    w = 54'd1000;
			4'd4:    w = 54'd10000;
			4'd5:    w = 54'd100000;
			4'd6:    w = 54'd1000000;
			4'd7:    w = 54'd10000000;
			4'd8:    w = 54'd100000000;
			4'd9:    w = 54'd1000000000;
			4'd10:   w = 54'd10000000000;
			4'd11:   w = 54'd100000000000;
			4'd12:   w = 54'd1000000000000;
			4'd13:   w = 54'd10000000000000;
			4'd14:   w = 54'd100000000000000;
			default: w = 54'd1000000000000000;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- sv/acfp_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module acfp_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/acfp_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acfp_ctrl
// Controller: sequences byte intake, the fraction conversion at a comma and
// the emission of field results at the end of a line.
// ----------------------------------------------------------------------------
module acfp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire acfp_pkg::status_t st,
	output acfp_pkg::cmd_t         cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_WR   = 5'b00100,
		ST_RD   = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.eol && st.emit_any) begin
						state_n = ST_RD;
					end else if (st.comma_kept) begin
						state_n = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_n = ST_WR;
				end
			end
			ST_WR: begin
				cmd.wr_comma = 1'b1;
				state_n      = ST_IDLE;
			end
			ST_RD: begin
				state_n = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (st.k_last) begin
						state_n = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_n     = ST_RD;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/acfp_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// acfp_dp
// Datapath: line bookkeeping, checksum, decimal and hex field parsing, the
// fraction-to-binary conversion, the field store and the result registers.
// ----------------------------------------------------------------------------
module acfp_dp #(
	parameter int unsigned MAX_LINE   = acfp_pkg::MAX_LINE_DEF,
	parameter int unsigned MAX_FIELDS = acfp_pkg::MAX_FIELDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [7:0]                    rx_byte,
	input  wire acfp_pkg::cmd_t                cmd,
	output acfp_pkg::status_t                  st,
	output logic                               record_kind,
	output logic [3:0]                         field_index,
	output logic signed [acfp_pkg::VALUE_W-1:0] value_fixed,
	output logic                               flag_value,
	output logic                               last_field
);

	localparam int unsigned LEN_W  = $clog2(MAX_LINE + 1);
	localparam int unsigned ADDR_W = $clog2(MAX_FIELDS);
	localparam int unsigned VW     = acfp_pkg::VALUE_W;
	localparam int unsigned FW     = acfp_pkg::FRAC_W;
	localparam logic [3:0] LIM_M = 4'((MAX_FIELDS - 1 < 7) ? MAX_FIELDS - 1 : 7);
	localparam logic [3:0] LIM_S = 4'((MAX_FIELDS - 1 < 11) ? MAX_FIELDS - 1 : 11);

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {DP_LEAD, DP_INT, DP_FRAC, DP_STOP} dec_ph_t;
	typedef enum logic [2:0] {HX_LEAD, HX_SIGN, HX_ZERO, HX_X, HX_DIG, HX_STOP} hex_ph_t;

	// Line state
	logic [LEN_W-1:0] line_len_q, lac_q;
	logic [7:0]       sum_q, sbc_q, first_q;
	logic [3:0]       fc_q;
	logic             doubled_q, prevcomma_q;
	// Number state
	dec_ph_t          dec_ph_q, dec_ph_n;
	logic             dec_neg_q, dec_neg_n;
	logic [31:0]      dec_q, dec_n;
	logic [FW-1:0]    frac_q, frac_n;
	logic [4:0]       fd_q, fd_n;
	hex_ph_t          hex_ph_q, hex_ph_n;
	logic [15:0]      hex_q, hex_n;
	logic [2:0]       hc_q, hc_n;
	logic             hex_neg_q, hex_neg_n;
	// Fraction conversion
	logic [15:0]      est_q, quo_q;
	logic             dcnt_q;
	logic [63:0]      est_prod;
	logic [FW-1:0]    est_back, est_rem;
	// Emission
	logic             kind_q;
	logic [3:0]       last_q, k_q;

	logic [7:0]  c;
	logic        blank, dig, is_eol, is_comma, kept;
	logic [3:0]  dval;
	logic [4:0]  hval;
	logic        hdig;
	logic [35:0] prod;
	logic [31:0] int_sat;
	logic [VW-1:0] mag, mag_c, field_val;
	logic        len_ok, match, kind_m, kind_s;
	logic [3:0]  lim, last0, last1, last_eff;
	logic        fc_fits;
	logic [VW-1:0] rdata;

	assign c        = rx_byte;
	assign blank    = (c >= 8'h09 && c <= CH_CR) || c == CH_SPACE;
	assign dig      = c >= CH_ZERO && c <= 8'h39;
	assign dval     = c[3:0];
	assign is_eol   = c == CH_CR || c == CH_LF;
	assign is_comma = c == CH_COMMA;
	assign kept     = line_len_q < LEN_W'(MAX_LINE);

	always_comb begin
		if (dig) begin
			hval = {1'b0, dval};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			hval = {1'b0, 4'(c[3:0] + 4'd9)};
		end else begin
			hval = 5'h10;
		end
	end
	assign hdig = !hval[4];

	assign prod    = {4'd0, dec_q} * 36'd10 + 36'(dval);
	assign int_sat = (prod > 36'h8000_0000) ? 32'h8000_0000 : prod[31:0];

	// Decimal field parser, one character a cycle while bytes are accepted.
	always_comb begin
		dec_ph_n  = dec_ph_q;
		dec_neg_n = dec_neg_q;
		dec_n     = dec_q;
		frac_n    = frac_q;
		fd_n      = fd_q;
		case (dec_ph_q)
			DP_LEAD: begin
				if (!blank) begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						dec_neg_n = dec_neg_q | (c == CH_MINUS);
						dec_ph_n  = DP_INT;
					end else if (dig) begin
						dec_n    = int_sat;
						dec_ph_n = DP_INT;
					end else if (c == CH_DOT) begin
						dec_ph_n = DP_FRAC;
					end else begin
						dec_ph_n = DP_STOP;
					end
				end
			end
			DP_INT: begin
				if (dig) begin
					dec_n = int_sat;
				end else if (c == CH_DOT) begin
					dec_ph_n = DP_FRAC;
				end else begin
					dec_ph_n = DP_STOP;
				end
			end
			DP_FRAC: begin
				if (dig) begin
					if (fd_q < 5'd16) begin
						frac_n = frac_q + FW'(dval)
							* acfp_pkg::frac_weight(4'(5'd15 - fd_q));
						fd_n   = fd_q + 5'd1;
					end
				end else begin
					dec_ph_n = DP_STOP;
				end
			end
			default: ;
		endcase
	end

	// Checksum text parser; only the first four characters count.
	always_comb begin
		hex_ph_n  = hex_ph_q;
		hex_n     = hex_q;
		hc_n      = hc_q;
		hex_neg_n = hex_neg_q;
		if (hc_q < 3'd4) begin
			hc_n = hc_q + 3'd1;
			case (hex_ph_q)
				HX_LEAD: begin
					if (!blank) begin
						if (c == CH_PLUS || c == CH_MINUS) begin
							hex_neg_n = hex_neg_q | (c == CH_MINUS);
							hex_ph_n  = HX_SIGN;
						end else if (c == CH_ZERO) begin
							hex_ph_n = HX_ZERO;
						end else if (hdig) begin
							hex_n    = {12'd0, hval[3:0]};
							hex_ph_n = HX_DIG;
						end else begin
							hex_ph_n = HX_STOP;
						end
					end
				end
				HX_SIGN: begin
					if (c == CH_ZERO) begin
						hex_ph_n = HX_ZERO;
					end else if (hdig) begin
						hex_n    = {12'd0, hval[3:0]};
						hex_ph_n = HX_DIG;
					end else begin
						hex_ph_n = HX_STOP;
					end
				end
				HX_ZERO: begin
					if (c == CH_X_LO || c == CH_X_UP) begin
						hex_ph_n = HX_X;
					end else if (hdig) begin
						hex_n    = {12'd0, hval[3:0]};
						hex_ph_n = HX_DIG;
					end else begin
						hex_ph_n = HX_STOP;
					end
				end
				HX_X: begin
					if (hdig) begin
						hex_n    = {12'd0, hval[3:0]};
						hex_ph_n = HX_DIG;
					end else begin
						hex_ph_n = HX_STOP;
					end
				end
				HX_DIG: begin
					if (hdig) begin
						hex_n = {hex_q[11:0], hval[3:0]};
					end else begin
						hex_ph_n = HX_STOP;
					end
				end
				default: ;
			endcase
		end
	end

	// Field value in Q31.16 with saturation.
	assign mag = {dec_q, 16'd0} | {32'd0, quo_q};
	always_comb begin
		if (dec_neg_q) begin
			mag_c     = (mag > {1'b1, {(VW-1){1'b0}}}) ? {1'b1, {(VW-1){1'b0}}} : mag;
			field_val = VW'(~mag_c + 1'b1);
		end else begin
			mag_c     = (mag > {1'b0, {(VW-1){1'b1}}}) ? {1'b0, {(VW-1){1'b1}}} : mag;
			field_val = mag_c;
		end
	end

	// End-of-line decision.
	assign len_ok   = line_len_q >= LEN_W'(4) && lac_q >= LEN_W'(1);
	assign match    = hex_neg_q ? (hex_q == 16'd0 && sbc_q == 8'd0) : (hex_q == {8'd0, sbc_q});
	assign kind_m   = first_q == CH_M;
	assign kind_s   = first_q == CH_S;
	assign lim      = kind_s ? LIM_S : LIM_M;
	assign last0    = fc_q - 4'd1;
	assign last1    = (doubled_q && last0 != 4'd0) ? last0 - 4'd1 : last0;
	assign last_eff = (last1 > lim) ? lim : last1;
	assign fc_fits  = {1'b0, fc_q} < 5'(MAX_FIELDS);

	assign st.eol        = is_eol;
	assign st.comma_kept = is_comma && kept;
	assign st.emit_any   = len_ok && match && lac_q >= LEN_W'(6) && (kind_m || kind_s)
		&& last_eff != 4'd0;
	assign st.div_last   = dcnt_q;
	assign st.k_last     = k_q == last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q  <= '0;
			lac_q       <= '0;
			sum_q       <= '0;
			sbc_q       <= '0;
			first_q     <= '0;
			fc_q        <= '0;
			doubled_q   <= 1'b0;
			prevcomma_q <= 1'b0;
			dec_ph_q    <= DP_LEAD;
			dec_neg_q   <= 1'b0;
			dec_q       <= '0;
			frac_q      <= '0;
			fd_q        <= '0;
			hex_ph_q    <= HX_LEAD;
			hex_q       <= '0;
			hc_q        <= '0;
			hex_neg_q   <= 1'b0;
			dcnt_q      <= 1'b0;
			kind_q      <= 1'b0;
			last_q      <= '0;
			k_q         <= '0;
		end else begin
			if (cmd.accept) begin
				if (is_eol) begin
					kind_q      <= kind_s;
					last_q      <= last_eff;
					k_q         <= 4'd1;
					line_len_q  <= '0;
					lac_q       <= '0;
					sum_q       <= '0;
					sbc_q       <= '0;
					first_q     <= '0;
					fc_q        <= '0;
					doubled_q   <= 1'b0;
					prevcomma_q <= 1'b0;
					dec_ph_q    <= DP_LEAD;
					dec_neg_q   <= 1'b0;
					dec_q       <= '0;
					frac_q      <= '0;
					fd_q        <= '0;
					hex_ph_q    <= HX_LEAD;
					hex_q       <= '0;
					hc_q        <= '0;
					hex_neg_q   <= 1'b0;
				end else if (kept && is_comma) begin
					dcnt_q <= 1'b0;
				end else if (kept) begin
					if (line_len_q == '0) begin
						first_q <= c;
					end
					dec_ph_q    <= dec_ph_n;
					dec_neg_q   <= dec_neg_n;
					dec_q       <= dec_n;
					frac_q      <= frac_n;
					fd_q        <= fd_n;
					hex_ph_q    <= hex_ph_n;
					hex_q       <= hex_n;
					hc_q        <= hc_n;
					hex_neg_q   <= hex_neg_n;
					prevcomma_q <= 1'b0;
					sum_q       <= sum_q + c;
					line_len_q  <= line_len_q + LEN_W'(1);
				end
			end
			if (cmd.div_step) begin
				dcnt_q <= !dcnt_q;
			end
			if (cmd.wr_comma) begin
				if (line_len_q == '0) begin
					first_q <= CH_COMMA;
				end
				doubled_q   <= prevcomma_q;
				lac_q       <= line_len_q;
				sbc_q       <= sum_q;
				if (fc_q != 4'd15) begin
					fc_q <= fc_q + 4'd1;
				end
				dec_ph_q    <= DP_LEAD;
				dec_neg_q   <= 1'b0;
				dec_q       <= '0;
				frac_q      <= '0;
				fd_q        <= '0;
				hex_ph_q    <= HX_LEAD;
				hex_q       <= '0;
				hc_q        <= '0;
				hex_neg_q   <= 1'b0;
				prevcomma_q <= 1'b1;
				sum_q       <= sum_q + CH_COMMA;
				line_len_q  <= line_len_q + LEN_W'(1);
			end
			if (cmd.advance) begin
				k_q <= k_q + 4'd1;
			end
		end
	end

	// The decimal fraction divided by 5^16, first an estimate, then a correction. The
	// reciprocal estimate from the top 32 bits is never above the true quotient and at
	// most one below it, so a single compare of the remainder finishes the job.
	assign est_prod = {32'd0, frac_q[FW-1:22]} * {32'd0, acfp_pkg::FRAC_RECIP};
	assign est_back = {38'd0, est_q} * {16'd0, acfp_pkg::FRAC_DIV};
	assign est_rem  = frac_q - est_back;

	always_ff @(posedge clk) begin
		if (cmd.div_step) begin
			if (!dcnt_q) begin
				est_q <= est_prod[62:47];
			end else if (est_rem >= {16'd0, acfp_pkg::FRAC_DIV}) begin
				quo_q <= est_q + 16'd1;
			end else begin
				quo_q <= est_q;
			end
		end
	end

	acfp_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_FIELDS)
	) u_fields (
		.clk  (clk),
		.we   (cmd.wr_comma && fc_fits),
		.waddr(fc_q[ADDR_W-1:0]),
		.wdata(field_val),
		.raddr(k_q[ADDR_W-1:0]),
		.rdata(rdata)
	);

	assign record_kind = kind_q;
	assign field_index = k_q;
	assign value_fixed = rdata;
	assign last_field  = k_q == last_q;
	assign flag_value  = rdata[VW-1] ? !(&rdata[VW-1:16] && |rdata[15:0]) : |rdata[VW-1:16];

endmodule
`default_nettype wire

// ----- sv/ascii_checksum_frame_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_checksum_frame_parser
// Parses comma-separated ASCII reply lines with an 8-bit additive checksum
// and emits one fixed-point result per data field of good M and S lines, up to a per-kind limit.
// ----------------------------------------------------------------------------
// A comma within the line limit is followed by the turning of the field's
// decimal fraction into 16 binary fraction bits (a reciprocal multiplication,
// then one correction step) and the storing of the field; no byte is taken
// until the field is stored. A CR or LF that closes a good line is followed,
// for each field result, by a store read and then the result beat, which
// waits while out_ready is low; no byte is taken during emission. The field
// store needs no clearing pass after reset.
module ascii_checksum_frame_parser #(
	parameter int unsigned MAX_LINE   = acfp_pkg::MAX_LINE_DEF,
	parameter int unsigned MAX_FIELDS = acfp_pkg::MAX_FIELDS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [7:0]                           rx_byte,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      record_kind,
	output logic [3:0]                                field_index,
	output logic signed [acfp_pkg::VALUE_W-1:0]       value_fixed,
	output logic                                      flag_value,
	output logic                                      last_field
);

	acfp_pkg::cmd_t    cmd;
	acfp_pkg::status_t st;

	acfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.cmd      (cmd)
	);

	acfp_dp #(
		.MAX_LINE  (MAX_LINE),
		.MAX_FIELDS(MAX_FIELDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.st         (st),
		.record_kind(record_kind),
		.field_index(field_index),
		.value_fixed(value_fixed),
		.flag_value (flag_value),
		.last_field (last_field)
	);

endmodule
`default_nettype wire

// ----- sim/tb_ascii_checksum_frame_parser.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_checksum_frame_parser
// Feeds reply lines byte by byte into the frame parser, predicts each field
// beat from a behavioural line model and compares every beat in order.
// ----------------------------------------------------------------------------
module tb_ascii_checksum_frame_parser;

	localparam int unsigned LINE_LIMIT  = acfp_pkg::MAX_LINE_DEF;
	localparam int unsigned FIELD_SLOTS = acfp_pkg::MAX_FIELDS_DEF;
	localparam int unsigned ITEM_TARGET = 1000;
	localparam logic [47:0] POS_CAP = 48'h7FFFFFFFFFFF;
	localparam logic [47:0] NEG_CAP = 48'h800000000000;
	localparam logic [63:0] FRAC_DIVISOR = 64'd152587890625;

	typedef enum logic [2:0] {DEC_LEAD, DEC_INT, DEC_FRAC, DEC_STOP} dec_phase_e;
	typedef enum logic [2:0] {HEX_LEAD, HEX_SIGN, HEX_ZERO, HEX_X, HEX_DIG, HEX_STOP} hex_phase_e;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	typedef struct packed {
		logic        kind;
		logic [3:0]  index;
		logic [47:0] value;
		logic        flag;
		logic        last;
	} field_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic record_kind;
	logic [3:0] field_index;
	logic signed [47:0] value_fixed;
	logic flag_value;
	logic last_field;

	ascii_checksum_frame_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.record_kind(record_kind), .field_index(field_index),
		.value_fixed(value_fixed), .flag_value(flag_value), .last_field(last_field)
	);

	always #6 clk = ~clk;

	// Line model state
	int unsigned    ln_len, ln_comma_pos;
	logic [7:0]     ln_sum, ln_sum_at_comma, ln_first;
	int unsigned    ln_commas;
	logic [63:0]    dec_int, dec_frac;
	int unsigned    dec_fdigits;
	dec_phase_e     dec_ph;
	logic           dec_neg, prev_comma, doubled;
	logic [15:0]    hex_val_acc;
	hex_phase_e     hex_ph;
	int unsigned    hex_seen;
	logic           hex_neg;
	logic [47:0]    field_store [FIELD_SLOTS];

	field_beat_t expected_beats[$];
	int unsigned errors = 0;
	int unsigned beats_seen = 0;
	int unsigned items_sent = 0;
	bit hold_off = 1'b0;

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $time, what);
		errors++;
	endtask

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
	endfunction

	function automatic void clear_number();
		dec_int = 0; dec_frac = 0; dec_fdigits = 0; dec_ph = DEC_LEAD; dec_neg = 0;
		hex_val_acc = 0; hex_ph = HEX_LEAD; hex_seen = 0; hex_neg = 0;
	endfunction

	function automatic void clear_line();
		ln_len = 0; ln_comma_pos = 0; ln_sum = 0; ln_sum_at_comma = 0; ln_first = 0;
		ln_commas = 0; prev_comma = 0; doubled = 0;
		clear_number();
	endfunction

	function automatic void add_int_digit(input logic [7:0] c);
		dec_int = dec_int * 10 + (c - "0");
		if (dec_int > 64'h80000000) dec_int = 64'h80000000;
	endfunction

	function automatic void feed_decimal(input logic [7:0] c);
		logic [63:0] w;
		bit dig;
		dig = c >= "0" && c <= "9";
		case (dec_ph)
			DEC_LEAD: begin
				if (is_space(c)) ;
				else if (c == "+" || c == "-") begin
					dec_neg = c == "-";
					dec_ph = DEC_INT;
				end else if (dig) begin
					add_int_digit(c);
					dec_ph = DEC_INT;
				end else if (c == ".") dec_ph = DEC_FRAC;
				else dec_ph = DEC_STOP;
			end
			DEC_INT: begin
				if (dig) add_int_digit(c);
				else if (c == ".") dec_ph = DEC_FRAC;
				else dec_ph = DEC_STOP;
			end
			DEC_FRAC: begin
				if (dig) begin
					if (dec_fdigits < 16) begin
						w = 1;
						repeat (15 - dec_fdigits) w = w * 10;
						dec_frac += (c - "0") * w;
						dec_fdigits++;
					end
				end else dec_ph = DEC_STOP;
			end
			default: ;
		endcase
	endfunction

	function automatic void feed_hex(input logic [7:0] c);
		int d;
		d = hex_digit(c);
		if (hex_seen >= 4) return;
		hex_seen++;
		case (hex_ph)
			HEX_LEAD: begin
				if (is_space(c)) ;
				else if (c == "+" || c == "-") begin
					if (c == "-") hex_neg = 1;
					hex_ph = HEX_SIGN;
				end else if (c == "0") hex_ph = HEX_ZERO;
				else if (d >= 0) begin hex_val_acc = 16'(d); hex_ph = HEX_DIG; end
				else hex_ph = HEX_STOP;
			end
			HEX_SIGN, HEX_X: begin
				if (hex_ph == HEX_SIGN && c == "0") hex_ph = HEX_ZERO;
				else if (d >= 0) begin hex_val_acc = 16'(d); hex_ph = HEX_DIG; end
				else hex_ph = HEX_STOP;
			end
			HEX_ZERO: begin
				if (c == "x" || c == "X") hex_ph = HEX_X;
				else if (d >= 0) begin hex_val_acc = 16'(d); hex_ph = HEX_DIG; end
				else hex_ph = HEX_STOP;
			end
			HEX_DIG: begin
				if (d >= 0) hex_val_acc = {hex_val_acc[11:0], 4'(d)};
				else hex_ph = HEX_STOP;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [47:0] closed_field_value();
		logic [63:0] mag;
		mag = (dec_int << 16) + dec_frac / FRAC_DIVISOR;
		if (dec_neg) begin
			if (mag > NEG_CAP) mag = NEG_CAP;
			return 48'(~mag + 1);
		end
		if (mag > POS_CAP) mag = POS_CAP;
		return mag[47:0];
	endfunction

	function automatic void close_line();
		bit good;
		logic kind;
		int limit, last;
		logic [47:0] v, mag;
		field_beat_t b;
		good = ln_len >= 4 && ln_comma_pos >= 1;
		if (good) good = hex_neg ? (hex_val_acc == 0 && ln_sum_at_comma == 0)
			: (hex_val_acc == {8'h00, ln_sum_at_comma});
		if (good && ln_comma_pos >= 6 && (ln_first == "M" || ln_first == "S")) begin
			kind = ln_first == "S";
			limit = kind ? 11 : 7;
			if (limit > FIELD_SLOTS - 1) limit = FIELD_SLOTS - 1;
			last = int'(ln_commas) - 1;
			if (doubled && last > 0) last--;
			if (last > limit) last = limit;
			for (int k = 1; k <= last; k++) begin
				v = field_store[k];
				mag = v[47] ? 48'(-v) : v;
				if (v == NEG_CAP) mag = NEG_CAP;
				b.kind = kind; b.index = 4'(k); b.value = v;
				b.flag = v[47] ? 1'b1 : (mag >= 48'd65536);
				if (v[47]) b.flag = (v == NEG_CAP) || (mag >= 48'd65536);
				b.last = k == last;
				expected_beats.push_back(b);
			end
		end
		clear_line();
	endfunction

	function automatic void predict_byte(input logic [7:0] c);
		if (c == CH_CR || c == CH_LF) begin
			close_line();
			return;
		end
		if (ln_len >= LINE_LIMIT) return;
		if (ln_len == 0) ln_first = c;
		if (c == CH_COMMA) begin
			if (ln_commas < FIELD_SLOTS) field_store[ln_commas] = closed_field_value();
			doubled = prev_comma;
			ln_comma_pos = ln_len;
			ln_sum_at_comma = ln_sum;
			if (ln_commas < 15) ln_commas++;
			clear_number();
			prev_comma = 1;
		end else begin
			feed_decimal(c);
			feed_hex(c);
			prev_comma = 0;
		end
		ln_sum = ln_sum + c;
		ln_len++;
	endfunction

	// Valid stays high from one beat to the next when no idle cycles are drawn.
	task automatic send_byte(input logic [7:0] c);
		int unsigned gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= c;
		do @(posedge clk); while (!in_ready);
		predict_byte(c);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// Appends the checksum of the body and a line end.
	task automatic send_framed(input string body, input bit hex_prefix, input bit lower);
		logic [7:0] sum;
		string h;
		sum = 0;
		for (int i = 0; i < body.len(); i++) sum += body[i];
		h = lower ? $sformatf("%0h", sum) : $sformatf("%0H", sum);
		if (hex_prefix) h = {"0x", h};
		send_text({body, ",", h, ($urandom_range(0, 1) ? "\r" : "\n")});
	endtask

	function automatic string random_number();
		string s;
		int unsigned shape;
		shape = $urandom_range(0, 9);
		s = "";
		case ($urandom_range(0, 3))
			0: s = "-";
			1: s = "+";
			default: ;
		endcase
		if (shape == 0) s = {s, $sformatf("%0d", $urandom)};
		else if (shape == 1) s = {s, "99999999999"};
		else s = {s, $sformatf("%0d", $urandom_range(0, 2000))};
		if ($urandom_range(0, 1)) begin
			s = {s, "."};
			repeat ($urandom_range(0, 18)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		end
		if (shape == 9) s = {" ", s, "e5"};
		return s;
	endfunction

	function automatic string random_body(input bit summary, input int unsigned nf);
		string s;
		s = summary ? "S" : "M";
		for (int i = 0; i < nf; i++) s = {s, ",", random_number()};
		return s;
	endfunction

	always @(posedge clk) begin
		field_beat_t e;
		if (out_valid && out_ready) begin
			beats_seen++;
			if (expected_beats.size() == 0)
				report_mismatch("field beat with nothing expected");
			else begin
				e = expected_beats.pop_front();
				if (record_kind !== e.kind) report_mismatch("record_kind");
				if (field_index !== e.index) report_mismatch("field_index");
				if (value_fixed !== e.value)
					report_mismatch($sformatf("value_fixed %h exp %h", value_fixed, e.value));
				if (flag_value !== e.flag) report_mismatch("flag_value");
				if (last_field !== e.last) report_mismatch("last_field");
			end
		end
	end

	// Receiver: idles a drawn number of cycles before each beat, and for as long
	// as it is held off.
	initial begin
		int unsigned stall;
		forever begin
			stall = $urandom_range(0, 6);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			while (hold_off) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic test_directed();
		send_text("\r\n");
		send_text("M,\r");
		send_framed("M,1,2,3,4,5,6,7,8", 1'b0, 1'b0);
		send_framed("S,-1.5,0.25,2147483648,99999999999,.5,-0,+7,1e3,x,0.0000152587890625,3",
			1'b1, 1'b1);
		send_framed("M,,0.9999999999999999999,,,,,", 1'b1, 1'b0);
		send_framed("S,1,2,", 1'b0, 1'b0);
		send_framed("Q,1,2,3,4", 1'b0, 1'b0);
		send_text("M1,2,3,00\n");
		send_text("M,1,2,3,-0\n");
		send_text("M,1,2,3,FF\n");
		send_text("MMMMMMMM\n");
		send_framed("M,-2147483649.99", 1'b0, 1'b0);
		send_framed(" S,\t 4", 1'b0, 1'b1);
	endtask

	// The filler runs through every byte value other than CR and LF and goes
	// past the line limit, so the checksum at the end is dropped.
	task automatic test_bytes_and_long_line();
		logic [7:0] c;
		send_text("M,1,2");
		for (int b = 0; b < LINE_LIMIT; b++) begin
			c = 8'(b);
			if (c == CH_CR || c == CH_LF) c = "A";
			send_byte(c);
		end
		send_text(",00\n");
	endtask

	task automatic test_random_lines();
		string body;
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
					send_byte(CH_LF);
				end
				1: begin
					body = random_body($urandom_range(0, 1), $urandom_range(0, 12));
					send_text({body, ",", $sformatf("%0h", $urandom_range(0, 255)), "\r"});
				end
				default: begin
					body = random_body($urandom_range(0, 1), $urandom_range(1, 12));
					send_framed(body, $urandom_range(0, 1), $urandom_range(0, 1));
				end
			endcase
		end
	endtask

	// The receiver stops while several good lines are offered, so the block
	// fills up and stalls its input.
	task automatic test_receiver_hold_off();
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (3) send_framed("S,1.5,-2,3,4,5,6,7,8,9,10,11", 1'b0, 1'b0);
		join
	endtask

	initial begin
		clear_line();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_bytes_and_long_line();
		test_receiver_hold_off();
		test_random_lines();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
